>>> rtl/cmds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Clock multiplier and divider search: shared definitions
// Field widths, register reset values, result codes and the microcode
// program that steps the search datapath.
// ----------------------------------------------------------------------------
package cmds_pkg;

	localparam int REF_W     = 10;
	localparam int VCO_CFG_W = 16;
	localparam int MAXO_W    = 12;
	localparam int TGT_W     = 12;
	localparam int MULT_W    = 8;
	localparam int DIV_W     = 8;
	localparam int FREQ_W    = 16;
	localparam int VCO_W     = REF_W + MULT_W;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;
	localparam int PC_W      = 4;

	localparam int MULT_MAX_DEF   = 64;
	localparam int DIVIDE_MAX_DEF = 128;
	localparam int MULT_FIRST     = 2;

	localparam logic [REF_W-1:0]     REF_RST     = REF_W'(300);
	localparam logic [VCO_CFG_W-1:0] VCO_MIN_RST = VCO_CFG_W'(800);
	localparam logic [VCO_CFG_W-1:0] VCO_MAX_RST = VCO_CFG_W'(1600);
	localparam logic [MAXO_W-1:0]    MAXO_RST    = MAXO_W'(800);

	localparam logic [1:0] REG_REF     = 2'd0;
	localparam logic [1:0] REG_VCO_MIN = 2'd1;
	localparam logic [1:0] REG_VCO_MAX = 2'd2;
	localparam logic [1:0] REG_MAX_OUT = 2'd3;

	typedef enum logic [1:0] {
		STAT_EXACT = 2'd0,
		STAT_NEAR  = 2'd1,
		STAT_BAD   = 2'd2,
		STAT_NONE  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_DIV_T,
		OP_DIV_STEP,
		OP_EXACT,
		OP_ROUND,
		OP_DIV_D,
		OP_TRACK,
		OP_ADVANCE,
		OP_EMIT,
		OP_EMIT_BAD
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_REQ,
		C_BAD_REQ,
		C_OUT_WIN,
		C_DIV_MORE,
		C_EXACT,
		C_D_OVER,
		C_LAST_M
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
		logic            hold_out;
	} ucode_t;

	localparam logic [PC_W-1:0] STEP_WAIT   = 4'd0;
	localparam logic [PC_W-1:0] STEP_VALID  = 4'd1;
	localparam logic [PC_W-1:0] STEP_WINDOW = 4'd2;
	localparam logic [PC_W-1:0] STEP_DIV1   = 4'd3;
	localparam logic [PC_W-1:0] STEP_EVAL1  = 4'd4;
	localparam logic [PC_W-1:0] STEP_ROUND  = 4'd5;
	localparam logic [PC_W-1:0] STEP_DIV2S  = 4'd6;
	localparam logic [PC_W-1:0] STEP_DIV2   = 4'd7;
	localparam logic [PC_W-1:0] STEP_TRACK  = 4'd8;
	localparam logic [PC_W-1:0] STEP_NEXT   = 4'd9;
	localparam logic [PC_W-1:0] STEP_ADV    = 4'd10;
	localparam logic [PC_W-1:0] STEP_EMIT   = 4'd11;
	localparam logic [PC_W-1:0] STEP_BAD    = 4'd12;

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '{op: OP_NONE, cond: C_ALWAYS, target: STEP_WAIT, hold_out: 1'b0};
		case (pc)
			STEP_WAIT:   w = '{op: OP_ACCEPT,   cond: C_NO_REQ,   target: STEP_WAIT,
			                   hold_out: 1'b0};
			STEP_VALID:  w = '{op: OP_NONE,     cond: C_BAD_REQ,  target: STEP_BAD,
			                   hold_out: 1'b0};
			STEP_WINDOW: w = '{op: OP_DIV_T,    cond: C_OUT_WIN,  target: STEP_NEXT,
			                   hold_out: 1'b0};
			STEP_DIV1:   w = '{op: OP_DIV_STEP, cond: C_DIV_MORE, target: STEP_DIV1,
			                   hold_out: 1'b0};
			STEP_EVAL1:  w = '{op: OP_EXACT,    cond: C_EXACT,    target: STEP_EMIT,
			                   hold_out: 1'b0};
			STEP_ROUND:  w = '{op: OP_ROUND,    cond: C_D_OVER,   target: STEP_NEXT,
			                   hold_out: 1'b0};
			STEP_DIV2S:  w = '{op: OP_DIV_D,    cond: C_NEVER,    target: STEP_WAIT,
			                   hold_out: 1'b0};
			STEP_DIV2:   w = '{op: OP_DIV_STEP, cond: C_DIV_MORE, target: STEP_DIV2,
			                   hold_out: 1'b0};
			STEP_TRACK:  w = '{op: OP_TRACK,    cond: C_NEVER,    target: STEP_WAIT,
			                   hold_out: 1'b0};
			STEP_NEXT:   w = '{op: OP_NONE,     cond: C_LAST_M,   target: STEP_EMIT,
			                   hold_out: 1'b0};
			STEP_ADV:    w = '{op: OP_ADVANCE,  cond: C_ALWAYS,   target: STEP_WINDOW,
			                   hold_out: 1'b0};
			STEP_EMIT:   w = '{op: OP_EMIT,     cond: C_ALWAYS,   target: STEP_WAIT,
			                   hold_out: 1'b1};
			STEP_BAD:    w = '{op: OP_EMIT_BAD, cond: C_ALWAYS,   target: STEP_WAIT,
			                   hold_out: 1'b1};
			default:     w = '{op: OP_NONE,     cond: C_ALWAYS,   target: STEP_WAIT,
			                   hold_out: 1'b0};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

>>> rtl/clock_mult_div_search_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Clock multiplier and divider search
// Finds a feedback multiplier and output divider for a requested frequency.
// ----------------------------------------------------------------------------
// A request carries target_mhz on a valid/ready channel; one result per
// request leaves on a valid/ready channel with status, feedback_mult,
// out_divide, achieved_mhz and error_mhz. The APB port sets the reference,
// the VCO window and the largest accepted request; the user must do so only
// while the block is idle, which the block does not enforce. A request is
// taken only when the sequencer waits at its first step, so one request is
// in work at a time; the next can be taken at the edge after the result is
// written. An invalid request goes from validation straight to its result.
// Each multiplier whose VCO is outside the window is skipped; otherwise a
// bit-serial division of the VCO by the target gives the divider. An exact
// quotient within the limit ends the search early; a rounded divider above
// the limit skips the multiplier, else a second division by it gives the
// achieved frequency, keeping the closest; both divisions share one divider.
// The result sits in an output register; a new request may be accepted
// while it waits. When the receiver stalls, the sequencer holds at its
// result step until the register frees up.
// Reset loads the default register values and returns the sequencer to
// its waiting step with no result pending.
// ----------------------------------------------------------------------------
module clock_mult_div_search_top #(
	parameter int MULT_MAX   = cmds_pkg::MULT_MAX_DEF,
	parameter int DIVIDE_MAX = cmds_pkg::DIVIDE_MAX_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [cmds_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [cmds_pkg::DATA_W-1:0]   pwdata,
	output logic      [cmds_pkg::DATA_W-1:0]   prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [cmds_pkg::TGT_W-1:0]    target_mhz,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output cmds_pkg::status_t                  status,
	output logic      [cmds_pkg::MULT_W-1:0]   feedback_mult,
	output logic      [cmds_pkg::DIV_W-1:0]    out_divide,
	output logic      [cmds_pkg::FREQ_W-1:0]   achieved_mhz,
	output logic      [cmds_pkg::FREQ_W-1:0]   error_mhz
);
	import cmds_pkg::*;

	localparam int DEN_W     = TGT_W;
	localparam int DIV_CNT_W = $clog2(VCO_W + 1);
	localparam logic [MULT_W-1:0]    MULT_LAST = MULT_W'(MULT_MAX);
	localparam logic [VCO_W-1:0]     DIV_LIM   = VCO_W'(DIVIDE_MAX);
	localparam logic [DIV_W-1:0]     DIV_LIM8  = DIV_W'(DIVIDE_MAX);
	localparam logic [MULT_W-1:0]    MULT_LOW  = MULT_W'(MULT_FIRST);
	localparam logic [DIV_CNT_W-1:0] DIV_LEN   = DIV_CNT_W'(VCO_W);
	localparam logic [VCO_W-1:0]     FREQ_SAT  = VCO_W'({FREQ_W{1'b1}});

	logic [REF_W-1:0]     ref_q;
	logic [VCO_CFG_W-1:0] vco_min_q;
	logic [VCO_CFG_W-1:0] vco_max_q;
	logic [MAXO_W-1:0]    max_out_q;
	logic                 cfg_wr;

	logic [PC_W-1:0]      pc_q;
	ucode_t               uc;
	op_t                  step_op;
	logic                 out_busy;
	logic                 cond_hit;
	logic                 emit_fire;

	logic [TGT_W-1:0]     t_q;
	logic [MULT_W-1:0]    m_q;
	logic [VCO_W-1:0]     vco_q;
	logic [DIV_W-1:0]     d_q;
	logic                 best_valid_q;
	logic [MULT_W-1:0]    best_mult_q;
	logic [DIV_W-1:0]     best_div_q;
	logic [VCO_W-1:0]     best_act_q;
	logic [VCO_W-1:0]     min_err_q;

	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [VCO_W-1:0]     quo_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [DEN_W:0]       rem_sh;
	logic                 rem_ge;

	logic                 out_valid_q;
	status_t              status_q;
	logic [MULT_W-1:0]    mult_out_q;
	logic [DIV_W-1:0]     div_out_q;
	logic [FREQ_W-1:0]    ach_out_q;
	logic [FREQ_W-1:0]    err_out_q;

	logic                 bad_req;
	logic                 out_win;
	logic                 exact_hit;
	logic [VCO_W-1:0]     d_full;
	logic                 d_over;
	logic [VCO_W-1:0]     t_ext;
	logic [VCO_W-1:0]     err_now;
	logic                 better;

	// Configuration registers.
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q     <= REF_RST;
			vco_min_q <= VCO_MIN_RST;
			vco_max_q <= VCO_MAX_RST;
			max_out_q <= MAXO_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_REF:     ref_q     <= pwdata[REF_W-1:0];
				REG_VCO_MIN: vco_min_q <= pwdata[VCO_CFG_W-1:0];
				REG_VCO_MAX: vco_max_q <= pwdata[VCO_CFG_W-1:0];
				REG_MAX_OUT: max_out_q <= pwdata[MAXO_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_REF:     prdata = DATA_W'(ref_q);
			REG_VCO_MIN: prdata = DATA_W'(vco_min_q);
			REG_VCO_MAX: prdata = DATA_W'(vco_max_q);
			REG_MAX_OUT: prdata = DATA_W'(max_out_q);
		endcase
	end

	// Datapath flags.
	assign t_ext   = VCO_W'(t_q);
	assign bad_req = (t_q == '0) || (t_q > max_out_q);
	assign out_win = (vco_q < VCO_W'(vco_min_q)) || (vco_q > VCO_W'(vco_max_q));
	assign exact_hit = (rem_q == '0) && (quo_q != '0) && (quo_q <= DIV_LIM);
	assign d_full  = quo_q + VCO_W'(rem_q >= (t_q - (t_q >> 1)));
	assign d_over  = d_full > DIV_LIM;
	assign err_now = (quo_q > t_ext) ? (quo_q - t_ext) : (t_ext - quo_q);
	assign better  = !best_valid_q || (err_now < min_err_q);

	assign rem_sh = {rem_q, quo_q[VCO_W-1]};
	assign rem_ge = rem_sh >= {1'b0, den_q};

	// Sequencer.
	assign uc       = ucode_rom(pc_q);
	assign out_busy = out_valid_q && !out_ready;
	assign in_ready = (pc_q == STEP_WAIT);

	always_comb begin
		if (uc.hold_out && out_busy) begin
			step_op = OP_NONE;
		end else if (uc.op == OP_ACCEPT && !in_valid) begin
			step_op = OP_NONE;
		end else begin
			step_op = uc.op;
		end
	end

	assign emit_fire = (step_op == OP_EMIT) || (step_op == OP_EMIT_BAD);

	always_comb begin
		unique case (uc.cond)
			C_NEVER:    cond_hit = 1'b0;
			C_ALWAYS:   cond_hit = 1'b1;
			C_NO_REQ:   cond_hit = !in_valid;
			C_BAD_REQ:  cond_hit = bad_req;
			C_OUT_WIN:  cond_hit = out_win;
			C_DIV_MORE: cond_hit = div_cnt_q != DIV_CNT_W'(1);
			C_EXACT:    cond_hit = exact_hit;
			C_D_OVER:   cond_hit = d_over;
			C_LAST_M:   cond_hit = m_q == MULT_LAST;
			default:    cond_hit = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_WAIT;
		end else if (uc.hold_out && out_busy) begin
			pc_q <= pc_q;
		end else if (cond_hit) begin
			pc_q <= uc.target;
		end else begin
			pc_q <= pc_q + PC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (step_op == OP_DIV_T || step_op == OP_DIV_D) begin
			div_cnt_q <= DIV_LEN;
		end else if (step_op == OP_DIV_STEP && div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (step_op)
			OP_ACCEPT: begin
				t_q          <= target_mhz;
				m_q          <= MULT_LOW;
				vco_q        <= VCO_W'({ref_q, 1'b0});
				best_valid_q <= 1'b0;
			end
			OP_DIV_T: begin
				quo_q <= vco_q;
				rem_q <= '0;
				den_q <= t_q;
			end
			OP_DIV_D: begin
				quo_q <= vco_q;
				rem_q <= '0;
				den_q <= DEN_W'(d_q);
			end
			OP_DIV_STEP: begin
				quo_q <= {quo_q[VCO_W-2:0], rem_ge};
				rem_q <= rem_ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
			end
			OP_EXACT: begin
				if (exact_hit) begin
					best_valid_q <= 1'b1;
					best_mult_q  <= m_q;
					best_div_q   <= quo_q[DIV_W-1:0];
					best_act_q   <= t_ext;
					min_err_q    <= '0;
				end
			end
			OP_ROUND: begin
				d_q <= (d_full == '0) ? DIV_W'(1) : d_full[DIV_W-1:0];
			end
			OP_TRACK: begin
				if (better) begin
					best_valid_q <= 1'b1;
					best_mult_q  <= m_q;
					best_div_q   <= d_q;
					best_act_q   <= quo_q;
					min_err_q    <= err_now;
				end
			end
			OP_ADVANCE: begin
				m_q   <= m_q + MULT_W'(1);
				vco_q <= vco_q + VCO_W'(ref_q);
			end
			OP_EMIT: begin
				if (best_valid_q) begin
					status_q   <= (min_err_q == '0) ? STAT_EXACT : STAT_NEAR;
					mult_out_q <= best_mult_q;
					div_out_q  <= best_div_q;
					ach_out_q  <= (best_act_q > FREQ_SAT) ? '1 : best_act_q[FREQ_W-1:0];
					err_out_q  <= (min_err_q > FREQ_SAT) ? '1 : min_err_q[FREQ_W-1:0];
				end else begin
					status_q   <= STAT_NONE;
					mult_out_q <= '0;
					div_out_q  <= '0;
					ach_out_q  <= '0;
					err_out_q  <= '0;
				end
			end
			OP_EMIT_BAD: begin
				status_q   <= STAT_BAD;
				mult_out_q <= '0;
				div_out_q  <= '0;
				ach_out_q  <= '0;
				err_out_q  <= '0;
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign feedback_mult = mult_out_q;
	assign out_divide    = div_out_q;
	assign achieved_mhz  = ach_out_q;
	assign error_mhz     = err_out_q;

`ifndef SYNTH
	a_accept_enters_check: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (pc_q == STEP_VALID))
		else $error("Accepted request did not move the sequencer to validation.");

	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |=> out_valid_q)
		else $error("Result write did not raise out_valid.");

	a_fail_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == STAT_BAD || status_q == STAT_NONE))
		|-> (mult_out_q == '0 && div_out_q == '0 && ach_out_q == '0 && err_out_q == '0))
		else $error("Failed search reported nonzero settings.");

	a_found_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == STAT_EXACT || status_q == STAT_NEAR))
		|-> (div_out_q != '0 && div_out_q <= DIV_LIM8 && mult_out_q >= MULT_LOW
			&& mult_out_q <= MULT_LAST))
		else $error("Reported multiplier or divider outside its limits.");

	a_div_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_cnt_q <= DIV_LEN)
		else $error("Divider step count out of range.");
`endif

endmodule
`default_nettype wire
